### sv/evs_pkg.sv
// shared types and constants for the eviction victim selector
package evs_pkg;

  localparam int unsigned MAX_APPS    = 256;
  localparam int unsigned MEMORY_BITS = 48;

  // field widths fixed by the interface
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned MEM_FIELD_W = 48;
  localparam int unsigned VPOS_W     = 8;

  // internal widths derived from the parameters
  localparam int unsigned POS_W = (MAX_APPS > 1) ? $clog2(MAX_APPS) : 1;
  localparam int unsigned MEM_W = (MEMORY_BITS < MEM_FIELD_W) ? MEMORY_BITS : MEM_FIELD_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_APPS - 1);

  localparam logic [PRIO_W-1:0] DEFAULT_PRIO_RST = PRIO_W'(2);

  typedef enum logic [1:0] {
    LIFE_OTHER      = 2'd0,
    LIFE_PAUSED     = 2'd1,
    LIFE_SUSPENDED  = 2'd2,
    LIFE_HIBERNATED = 2'd3
  } life_e;

  typedef struct packed {
    logic [1:0]             life_state;
    logic                   priority_present;
    logic [PRIO_W-1:0]      app_priority;
    logic [MEM_FIELD_W-1:0] memory_usage;
    logic                   last_app;
  } evs_in_t;

  typedef struct packed {
    logic              victim_found;
    logic [VPOS_W-1:0] victim_position;
    logic              victim_hibernated;
  } evs_out_t;

  // bucket view after the current item is folded in
  typedef struct packed {
    logic             nonzero;
    logic             one;
    logic [POS_W-1:0] pos;
  } bkt_stat_t;

endpackage

### sv/evs_in_reg.sv
// input register stage holding one item
module evs_in_reg import evs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  evs_in_t in_item_i,
  output logic    in_stall_o,
  input  logic    take_i,
  output logic    valid_o,
  output evs_in_t item_o
);

  logic    valid_q, valid_d;
  evs_in_t item_q;
  logic    load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### sv/evs_bucket.sv
// one lifecycle bucket: saturating count and best candidate
module evs_bucket import evs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hit_i,
  input  logic              clear_i,
  input  logic [PRIO_W-1:0] prio_i,
  input  logic [MEM_W-1:0]  mem_i,
  input  logic [POS_W-1:0]  pos_i,
  output bkt_stat_t         stat_o
);

  logic [1:0]        cnt_q, cnt_d;
  logic [PRIO_W-1:0] prio_q;
  logic [MEM_W-1:0]  mem_q;
  logic [POS_W-1:0]  pos_q;
  logic              beats;
  logic              upd;

  // priority, then memory, then stalest position; later item wins a full tie
  always_comb begin
    beats = (cnt_q == 2'd0) || (prio_i > prio_q) ||
            ((prio_i == prio_q) &&
             ((mem_i > mem_q) || ((mem_i == mem_q) && (pos_i >= pos_q))));
    upd   = hit_i && beats;
    cnt_d = cnt_q;
    if (hit_i && (cnt_q != 2'd3)) begin
      cnt_d = cnt_q + 2'd1;
    end
    stat_o.nonzero = (cnt_d != 2'd0);
    stat_o.one     = (cnt_d == 2'd1);
    stat_o.pos     = upd ? pos_i : pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (clear_i) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      prio_q <= prio_i;
      mem_q  <= mem_i;
      pos_q  <= pos_i;
    end
  end

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> (cnt_q == 2'd0))
    else $error("bucket count not cleared after last item");

endmodule

### sv/evs_select.sv
// victim choice across buckets and the result register
module evs_select import evs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  bkt_stat_t paused_i,
  input  bkt_stat_t suspended_i,
  input  bkt_stat_t hibernated_i,
  input  logic      out_stall_i,
  output logic      free_o,
  output logic      out_valid_o,
  output evs_out_t  out_item_o
);

  logic     valid_q, valid_d;
  evs_out_t res_q, res_d;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    res_d = '0;
    if (paused_i.one) begin
      res_d.victim_found    = 1'b1;
      res_d.victim_position = VPOS_W'(paused_i.pos);
    end else if (suspended_i.nonzero) begin
      res_d.victim_found    = 1'b1;
      res_d.victim_position = VPOS_W'(suspended_i.pos);
    end else if (hibernated_i.nonzero) begin
      res_d.victim_found      = 1'b1;
      res_d.victim_position   = VPOS_W'(hibernated_i.pos);
      res_d.victim_hibernated = 1'b1;
    end
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = res_q;

endmodule

### sv/eviction_victim_selector.sv
// eviction victim selector top level
//   channel | direction | handshake                | payload
//   cfg     | in        | cfg_we_i                 | cfg_wdata_i (default priority)
//   in      | in        | in_valid_i / in_stall_o  | in_item_i (evs_in_t)
//   out     | out       | out_valid_o / out_stall_i| out_item_o (evs_out_t)
// one item per cycle while the input is not stalled; the input register holds each
// item until it is processed, and the result of a last item appears on the output the cycle after it is processed
// the bucket compare (priority, memory, position) sits between the two registers
// reset clears counters and valids; default priority resets to 2
// a non-last item is processed even while a result waits on a stalled output
module eviction_victim_selector import evs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PRIO_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  evs_in_t           in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output evs_out_t          out_item_o
);

  logic [PRIO_W-1:0] dflt_prio_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              cur_valid;
  evs_in_t           cur;
  logic              out_free;
  logic              proc;
  logic              fire;
  logic [PRIO_W-1:0] eff_prio;
  logic [MEM_W-1:0]  eff_mem;
  logic              keep;
  bkt_stat_t         st_paused, st_suspended, st_hibernated;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_prio_q <= DEFAULT_PRIO_RST;
    end else if (cfg_we_i) begin
      dflt_prio_q <= cfg_wdata_i;
    end
  end

  evs_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .take_i     (proc),
    .valid_o    (cur_valid),
    .item_o     (cur)
  );

  // a last item waits only for room in the result register
  assign proc     = cur_valid && (!cur.last_app || out_free);
  assign fire     = proc && cur.last_app;
  assign eff_prio = cur.priority_present ? cur.app_priority : dflt_prio_q;
  assign eff_mem  = MEM_W'(cur.memory_usage);
  assign keep     = proc && (eff_prio != '0);

  always_comb begin
    pos_d = pos_q;
    if (fire) begin
      pos_d = '0;
    end else if (proc && (pos_q != POS_MAX)) begin
      pos_d = pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  evs_bucket u_paused (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .hit_i   (keep && (cur.life_state == LIFE_PAUSED)),
    .clear_i (fire),
    .prio_i  (eff_prio),
    .mem_i   (eff_mem),
    .pos_i   (pos_q),
    .stat_o  (st_paused)
  );

  evs_bucket u_suspended (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .hit_i   (keep && (cur.life_state == LIFE_SUSPENDED)),
    .clear_i (fire),
    .prio_i  (eff_prio),
    .mem_i   (eff_mem),
    .pos_i   (pos_q),
    .stat_o  (st_suspended)
  );

  evs_bucket u_hibernated (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .hit_i   (keep && (cur.life_state == LIFE_HIBERNATED)),
    .clear_i (fire),
    .prio_i  (eff_prio),
    .mem_i   (eff_mem),
    .pos_i   (pos_q),
    .stat_o  (st_hibernated)
  );

  evs_select u_select (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .paused_i     (st_paused),
    .suspended_i  (st_suspended),
    .hibernated_i (st_hibernated),
    .out_stall_i  (out_stall_i),
    .free_o       (out_free),
    .out_valid_o  (out_valid_o),
    .out_item_o   (out_item_o)
  );

  a_pos_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (pos_q == '0))
    else $error("position counter not cleared after last item");

  a_pos_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !cur.last_app) |=> (pos_q >= $past(pos_q)))
    else $error("position counter moved backward");

  a_no_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.victim_found) |->
      ((out_item_o.victim_position == '0) && !out_item_o.victim_hibernated))
    else $error("no-victim result carries nonzero fields");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (cur_valid && cur.last_app && !out_free))
    else $error("input stalled without a blocked last item");

endmodule

### bench/evs_victim_checker.sv
// victim selection checker: tracks the buckets per enumeration and checks each result
module evs_victim_checker import evs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PRIO_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  evs_in_t           in_item_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  evs_out_t          out_item_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int BKT_PAUSED     = 0;
  localparam int BKT_SUSPENDED  = 1;
  localparam int BKT_HIBERNATED = 2;
  localparam int NUM_BKT        = 3;

  logic [PRIO_W-1:0] dflt_prio;
  logic [POS_W-1:0]  next_pos;
  logic [1:0]        bkt_cnt  [NUM_BKT];
  logic [PRIO_W-1:0] bkt_prio [NUM_BKT];
  logic [MEM_W-1:0]  bkt_mem  [NUM_BKT];
  logic [POS_W-1:0]  bkt_pos  [NUM_BKT];
  evs_out_t          victim_q [$];

  task automatic clear_enum();
    next_pos = '0;
    for (int b = 0; b < NUM_BKT; b++) begin
      bkt_cnt[b]  = '0;
      bkt_prio[b] = '0;
      bkt_mem[b]  = '0;
      bkt_pos[b]  = '0;
    end
  endtask

  // fold one app into its bucket; on the final app queue the victim
  task automatic fold_app(input evs_in_t app);
    logic [PRIO_W-1:0] prio;
    logic [MEM_W-1:0]  mem;
    logic [POS_W-1:0]  pos;
    logic              lead;
    int                b;
    evs_out_t          res;
    prio = app.priority_present ? app.app_priority : dflt_prio;
    mem  = app.memory_usage[MEM_W-1:0];
    pos  = next_pos;
    b    = -1;
    if (next_pos != POS_MAX) next_pos++;
    case (life_e'(app.life_state))
      LIFE_PAUSED:     b = BKT_PAUSED;
      LIFE_SUSPENDED:  b = BKT_SUSPENDED;
      LIFE_HIBERNATED: b = BKT_HIBERNATED;
      default:         b = -1;
    endcase
    if (prio != '0 && b >= 0) begin
      // priority, then memory, then stalest position; saturated positions tie, later wins
      if (bkt_cnt[b] == '0) lead = 1'b1;
      else if (prio != bkt_prio[b]) lead = prio > bkt_prio[b];
      else if (mem != bkt_mem[b]) lead = mem > bkt_mem[b];
      else lead = pos >= bkt_pos[b];
      if (lead) begin
        bkt_prio[b] = prio;
        bkt_mem[b]  = mem;
        bkt_pos[b]  = pos;
      end
      if (bkt_cnt[b] != 2'd3) bkt_cnt[b]++;
    end
    if (app.last_app) begin
      res = '0;
      b = -1;
      if (bkt_cnt[BKT_PAUSED] == 2'd1) b = BKT_PAUSED;
      else if (bkt_cnt[BKT_SUSPENDED] != '0) b = BKT_SUSPENDED;
      else if (bkt_cnt[BKT_HIBERNATED] != '0) b = BKT_HIBERNATED;
      if (b >= 0) begin
        res.victim_found      = 1'b1;
        res.victim_position   = VPOS_W'(bkt_pos[b]);
        res.victim_hibernated = (b == BKT_HIBERNATED);
      end
      victim_q.push_back(res);
      clear_enum();
    end
  endtask

  task automatic check_victim(input evs_out_t got);
    evs_out_t want;
    if (victim_q.size() == 0) begin
      $display("%0t: victim result with none expected: found=%0b pos=%0d hib=%0b",
               $time, got.victim_found, got.victim_position, got.victim_hibernated);
      fail_count_o++;
    end else begin
      want = victim_q.pop_front();
      if (got.victim_found !== want.victim_found) begin
        $display("%0t: victim_found expected %0b actual %0b",
                 $time, want.victim_found, got.victim_found);
        fail_count_o++;
      end
      if (got.victim_position !== want.victim_position) begin
        $display("%0t: victim_position expected %0d actual %0d",
                 $time, want.victim_position, got.victim_position);
        fail_count_o++;
      end
      if (got.victim_hibernated !== want.victim_hibernated) begin
        $display("%0t: victim_hibernated expected %0b actual %0b",
                 $time, want.victim_hibernated, got.victim_hibernated);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_prio = DEFAULT_PRIO_RST;
      clear_enum();
      victim_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) dflt_prio = cfg_wdata_i;
      // retire first so a result is never matched against an item taken this cycle
      if (out_valid_i && !out_stall_i) check_victim(out_item_i);
      if (in_valid_i && !in_stall_i) fold_app(in_item_i);
      pending_o <= victim_q.size();
    end
  end

endmodule

### bench/tb_eviction_victim_selector.sv
// testbench top for the eviction victim selector: stimulus, idling and verdict
module tb_eviction_victim_selector;
  import evs_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [PRIO_W-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  evs_in_t           in_item_i;
  logic              out_valid_o;
  logic              out_stall_i;
  evs_out_t          out_item_o;

  int fail_count;
  int results_pending;
  int send_idle_pct;
  int stall_pct;
  int apps_sent;

  localparam logic [MEM_FIELD_W-1:0] MEM_FULL = '1;

  eviction_victim_selector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  evs_victim_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (results_pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  function automatic evs_in_t make_app(input life_e life, input logic present,
                                       input logic [PRIO_W-1:0] prio,
                                       input logic [MEM_FIELD_W-1:0] mem,
                                       input logic final_app);
    evs_in_t app;
    app.life_state       = life;
    app.priority_present = present;
    app.app_priority     = prio;
    app.memory_usage     = mem;
    app.last_app         = final_app;
    return app;
  endfunction

  // priorities and memory sizes lean toward few values so ties are common
  function automatic evs_in_t rand_app(input logic final_app);
    logic [PRIO_W-1:0]      prio;
    logic [MEM_FIELD_W-1:0] mem;
    case ($urandom_range(7))
      0:       prio = '0;
      1:       prio = '1;
      2, 3:    prio = PRIO_W'($urandom_range(3, 1));
      default: prio = PRIO_W'($urandom_range(255));
    endcase
    case ($urandom_range(3))
      0:       mem = '0;
      1:       mem = MEM_FULL;
      2:       mem = MEM_FIELD_W'($urandom_range(3));
      default: mem = MEM_FIELD_W'({$urandom(), $urandom()});
    endcase
    return make_app(life_e'($urandom_range(3)), ($urandom_range(3) != 0), prio, mem,
                    final_app);
  endfunction

  task automatic send_item(input evs_in_t app);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= app;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apps_sent++;
  endtask

  task automatic send_enum(input int len);
    if (len == 0) send_item(make_app(LIFE_OTHER, 1'b0, '0, '0, 1'b1));
    for (int i = 0; i < len; i++) send_item(rand_app(i == len - 1));
  endtask

  // wait for every victim to come back, then let the pipeline empty
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [PRIO_W-1:0] prio);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= prio;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input int idle_pct, input int hold_pct,
                           input logic [PRIO_W-1:0] prio, input int target);
    int start;
    int len;
    start = apps_sent;
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    cfg_write(prio);
    // one enumeration long enough to saturate the position counter
    send_enum($urandom_range(300, 256));
    while (apps_sent - start < target) begin
      case ($urandom_range(9))
        0:       len = 0;
        1:       len = $urandom_range(40, 13);
        default: len = $urandom_range(12, 1);
      endcase
      send_enum(len);
    end
    drain();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    out_stall_i   = 1'b0;
    send_idle_pct = 16;
    stall_pct     = 80;
    apps_sent     = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default priority from reset
    send_item(make_app(LIFE_OTHER, 1'b1, 8'd9, '0, 1'b1));
    send_item(make_app(LIFE_PAUSED, 1'b0, '0, MEM_FULL, 1'b1));
    // two paused, dropped suspended, so the hibernated one is chosen
    send_item(make_app(LIFE_PAUSED, 1'b1, 8'd255, '0, 1'b0));
    send_item(make_app(LIFE_PAUSED, 1'b1, 8'd1, MEM_FULL, 1'b0));
    send_item(make_app(LIFE_SUSPENDED, 1'b1, 8'd0, MEM_FULL, 1'b0));
    send_item(make_app(LIFE_HIBERNATED, 1'b1, 8'd255, 48'd7, 1'b1));
    // full tie goes to the stalest position
    send_item(make_app(LIFE_SUSPENDED, 1'b1, 8'd7, 48'd5, 1'b0));
    send_item(make_app(LIFE_SUSPENDED, 1'b1, 8'd7, 48'd5, 1'b0));
    send_item(make_app(LIFE_SUSPENDED, 1'b1, 8'd7, 48'd4, 1'b0));
    send_item(make_app(LIFE_OTHER, 1'b1, 8'd200, MEM_FULL, 1'b1));
    // memory decides on equal priority, lower priority loses on equal memory
    send_item(make_app(LIFE_HIBERNATED, 1'b1, 8'd3, MEM_FULL, 1'b0));
    send_item(make_app(LIFE_HIBERNATED, 1'b1, 8'd3, '0, 1'b0));
    send_item(make_app(LIFE_HIBERNATED, 1'b1, 8'd2, MEM_FULL, 1'b1));
    drain();

    // zero default drops every app without a stored priority
    cfg_write(8'd0);
    send_item(make_app(LIFE_PAUSED, 1'b0, 8'd50, MEM_FULL, 1'b0));
    send_item(make_app(LIFE_SUSPENDED, 1'b1, 8'd9, 48'd1, 1'b0));
    send_item(make_app(LIFE_HIBERNATED, 1'b0, 8'd50, MEM_FULL, 1'b1));
    send_item(make_app(LIFE_HIBERNATED, 1'b0, 8'd255, MEM_FULL, 1'b1));
    drain();

    cfg_write(8'd255);
    send_item(make_app(LIFE_PAUSED, 1'b0, '0, '0, 1'b0));
    send_item(make_app(LIFE_PAUSED, 1'b1, 8'd255, 48'd1, 1'b0));
    send_item(make_app(LIFE_SUSPENDED, 1'b0, '0, 48'h8000_0000_0000, 1'b1));
    drain();

    run_phase(16, 80, PRIO_W'($urandom_range(254, 1)), 490);
    run_phase(80, 16, 8'd0, 490);
    run_phase(0, 0, 8'd255, 490);

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && results_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule
